[src/ihrc_pkg.sv]
// package for the ipv4 header receive check
// holds widths, verdict codes and the structs shared by the rtl files
// no dependencies
`default_nettype none

package ihrc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned VERDICT_W = 3;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [PADDR_W-1:0] REG_LOCAL_ADDRESS = 3'd0;

    localparam logic [3:0]          IP_VERSION   = 4'd4;
    localparam logic [3:0]          MIN_IHL      = 4'd5;
    localparam logic [COUNT_W-1:0]  MIN_HDR_LEN  = 16'd20;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hffff;
    localparam logic [15:0]         SUM_GOOD     = 16'hffff;
    localparam logic [COUNT_W-1:0]  TTL_POS      = 16'd8;
    localparam logic [COUNT_W-1:0]  DEST_FIRST   = 16'd16;
    localparam logic [COUNT_W-1:0]  DEST_LAST    = 16'd19;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ACCEPT    = 3'd0,
        VERDICT_VERSION   = 3'd1,
        VERDICT_TTL       = 3'd2,
        VERDICT_HDR_LEN   = 3'd3,
        VERDICT_DEST      = 3'd4,
        VERDICT_CHECKSUM  = 3'd5,
        VERDICT_TRUNCATED = 3'd6
    } t_verdict;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_step;

    typedef struct packed {
        t_verdict           verdict;
        logic [COUNT_W-1:0] packet_bytes;
    } t_result;

endpackage

`default_nettype wire

[src/ihrc_in_if.sv]
// input channel of the ipv4 header receive check: one packet byte per item
// depends on ihrc_pkg
`default_nettype none

interface ihrc_in_if;
    logic                        valid;
    logic                        ready;
    logic [ihrc_pkg::BYTE_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[src/ihrc_out_if.sv]
// output channel of the ipv4 header receive check: one verdict item per packet
// depends on ihrc_pkg
`default_nettype none

interface ihrc_out_if;
    logic                           valid;
    logic                           ready;
    logic [ihrc_pkg::VERDICT_W-1:0] verdict;
    logic [ihrc_pkg::COUNT_W-1:0]   packet_bytes;

    modport source (output valid, output verdict, output packet_bytes, input ready);
    modport sink   (input valid, input verdict, input packet_bytes, output ready);
endinterface

`default_nettype wire

[src/ihrc_hdr_track.sv]
// per-packet header state: field capture, running header sum, byte count
// gives the verdict for the byte being stepped; depends on ihrc_pkg
`default_nettype none

module ihrc_hdr_track (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ihrc_pkg::t_step              i_step,
    input  wire logic [ihrc_pkg::ADDR_W-1:0]  i_local_address,
    output ihrc_pkg::t_result                 o_result
);

    logic [ihrc_pkg::COUNT_W-1:0] r_pos, n_pos;
    logic [7:0]                   r_vl, n_vl;
    logic [7:0]                   r_ttl, n_ttl;
    logic [ihrc_pkg::ADDR_W-1:0]  r_dest, n_dest;
    logic [15:0]                  r_sum, n_sum;
    logic [7:0]                   r_hold, n_hold;

    logic [5:0]  hdr_bytes;
    logic        in_hdr;
    logic [16:0] sum_raw;
    logic [7:0]  b;

    always_comb begin
        b      = i_step.data_byte;
        n_vl   = (r_pos == '0) ? b : r_vl;
        n_ttl  = (r_pos == ihrc_pkg::TTL_POS) ? b : r_ttl;
        n_dest = (r_pos >= ihrc_pkg::DEST_FIRST && r_pos <= ihrc_pkg::DEST_LAST) ?
                 {r_dest[ihrc_pkg::ADDR_W-9:0], b} : r_dest;

        hdr_bytes = {n_vl[3:0], 2'b00};
        in_hdr    = r_pos < {10'd0, hdr_bytes};

        // even header byte is held, odd byte completes a word for the sum
        sum_raw = {1'b0, r_sum} + {1'b0, r_hold, b};
        n_hold  = r_hold;
        n_sum   = r_sum;
        if (in_hdr) begin
            if (!r_pos[0]) begin
                n_hold = b;
            end else begin
                n_sum = sum_raw[15:0] + {15'd0, sum_raw[16]};
            end
        end

        n_pos = (r_pos == ihrc_pkg::COUNT_MAX) ? r_pos : r_pos + 16'd1;
    end

    always_comb begin
        o_result.packet_bytes = n_pos;
        priority if (n_pos < ihrc_pkg::MIN_HDR_LEN || n_pos < {10'd0, hdr_bytes}) begin
            o_result.verdict = ihrc_pkg::VERDICT_TRUNCATED;
        end else if (n_vl[7:4] != ihrc_pkg::IP_VERSION) begin
            o_result.verdict = ihrc_pkg::VERDICT_VERSION;
        end else if (n_ttl == 8'd0) begin
            o_result.verdict = ihrc_pkg::VERDICT_TTL;
        end else if (n_vl[3:0] < ihrc_pkg::MIN_IHL) begin
            o_result.verdict = ihrc_pkg::VERDICT_HDR_LEN;
        end else if (n_dest != i_local_address) begin
            o_result.verdict = ihrc_pkg::VERDICT_DEST;
        end else if (n_sum != ihrc_pkg::SUM_GOOD) begin
            o_result.verdict = ihrc_pkg::VERDICT_CHECKSUM;
        end else begin
            o_result.verdict = ihrc_pkg::VERDICT_ACCEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_vl   <= '0;
            r_ttl  <= '0;
            r_dest <= '0;
            r_sum  <= '0;
            r_hold <= '0;
        end else if (i_step.valid) begin
            if (i_step.last_byte) begin
                r_pos  <= '0;
                r_vl   <= '0;
                r_ttl  <= '0;
                r_dest <= '0;
                r_sum  <= '0;
                r_hold <= '0;
            end else begin
                r_pos  <= n_pos;
                r_vl   <= n_vl;
                r_ttl  <= n_ttl;
                r_dest <= n_dest;
                r_sum  <= n_sum;
                r_hold <= n_hold;
            end
        end
    end

endmodule

`default_nettype wire

[src/ipv4_header_receive_check_unit.sv]
// ipv4 header receive check, top level
// uses ihrc_pkg, ihrc_in_if, ihrc_out_if and ihrc_hdr_track
//
// usage:
//   i_in carries a received packet one byte per item in wire order, with
//   last_byte set on the final byte. o_out carries one item per packet,
//   given for the final byte: the verdict (accept, bad version, zero ttl,
//   short header length, wrong destination, bad header sum, truncated, with
//   truncation checked first) and the saturating packet byte count.
//   the apb port holds local_address at byte address 0.
// timing:
//   one byte per cycle sustained unless a final byte waits on a blocked
//   output. a byte is registered at the input stage and stepped through
//   the header state while it sits there; the verdict for the final byte
//   is registered in the output register, which drives o_out.valid.
// reset:
//   synchronous active-low reset clears the per-packet state, local_address
//   and both stage valids; no clearing pass is needed.
// backpressure:
//   while a verdict waits on o_out.ready, bytes that are not final keep
//   flowing; a final byte waits in the input stage, and i_in.ready drops
//   only while that stage is full and cannot move.
`default_nettype none

module ipv4_header_receive_check_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ihrc_in_if.sink                            i_in,
    ihrc_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ihrc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ihrc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [ihrc_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    logic [ihrc_pkg::ADDR_W-1:0] r_local_address;

    logic                        r_s1_valid;
    logic [ihrc_pkg::BYTE_W-1:0] r_s1_byte;
    logic                        r_s1_last;

    logic                        r_out_valid;
    ihrc_pkg::t_result           r_out;

    logic              advance;
    ihrc_pkg::t_step   step;
    ihrc_pkg::t_result result;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr == ihrc_pkg::REG_LOCAL_ADDRESS) ? r_local_address : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
        end else if (psel && penable && pwrite && paddr == ihrc_pkg::REG_LOCAL_ADDRESS) begin
            r_local_address <= pwdata;
        end
    end

    // stage 1 moves on unless its item is final and the output is blocked
    assign advance    = !r_out_valid || o_out.ready || !r_s1_last;
    assign i_in.ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    always_comb begin
        step.valid     = r_s1_valid && advance;
        step.data_byte = r_s1_byte;
        step.last_byte = r_s1_last;
    end

    ihrc_hdr_track u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_local_address (r_local_address),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step.valid && step.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.valid && step.last_byte) begin
            r_out <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.verdict      = r_out.verdict;
    assign o_out.packet_bytes = r_out.packet_bytes;

endmodule

`default_nettype wire

[src/ihrc_checker.sv]
// port-level checks for the ipv4 header receive check
// bound to ipv4_header_receive_check_unit; depends on ihrc_pkg
`default_nettype none

module ihrc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [ihrc_pkg::VERDICT_W-1:0] out_verdict,
    input wire logic [ihrc_pkg::COUNT_W-1:0]   out_packet_bytes,
    input wire logic                           pready
);

    // a held verdict item keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_verdict)
            && $stable(out_packet_bytes))
        else $error("verdict item changed while stalled");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_verdict <= ihrc_pkg::VERDICT_TRUNCATED)
        else $error("verdict code out of range");

    // any verdict other than truncated needs at least a minimal header
    a_full_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_verdict != ihrc_pkg::VERDICT_TRUNCATED
            |-> out_packet_bytes >= ihrc_pkg::MIN_HDR_LEN)
        else $error("non-truncated verdict on a short packet");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !out_valid)
        else $error("verdict item present right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind ipv4_header_receive_check_unit ihrc_checker u_ihrc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .out_valid        (o_out.valid),
    .out_ready        (o_out.ready),
    .out_verdict      (o_out.verdict),
    .out_packet_bytes (o_out.packet_bytes),
    .pready           (pready)
);

`default_nettype wire

[test/ipv4_header_receive_check_unit_tb.sv]
`timescale 1ns / 1ps
// testbench for ipv4_header_receive_check_unit: packets go in byte by byte and each verdict
// is compared with its table entry or a predictor of the header checks; directed table first,
// then random packets; depends on ihrc_pkg, ihrc_in_if, ihrc_out_if and the unit itself

module ipv4_header_receive_check_unit_tb;
    import ihrc_pkg::*;

    localparam int CYCLE_LIMIT         = 1000000;
    localparam int DRAIN_CYCLES        = 6;
    localparam int RANDOM_BYTES        = 1500;
    localparam int MIN_RANDOM_VERDICTS = 60;
    localparam int N_CASES             = 22;

    typedef struct {
        bit          set_local;
        logic [31:0] local_value;
        logic [7:0]  ver_ihl;
        logic [7:0]  ttl;
        bit          dest_ok;
        bit          bad_sum;
        int          len;
        bit          typed;
        t_verdict    verdict;
        logic [15:0] count;
    } t_case;

    // set_local, local, ver_ihl, ttl, dest_ok, bad_sum, len, typed, verdict, count
    t_case directed_cases [N_CASES] = '{
        '{0, 32'h0,        8'h45, 8'h40, 1, 0, 20,    1, VERDICT_ACCEPT,    16'd20},
        '{1, 32'hffffffff, 8'h45, 8'hff, 1, 0, 20,    1, VERDICT_ACCEPT,    16'd20},
        '{1, 32'hc0a80001, 8'h4f, 8'h01, 1, 0, 60,    1, VERDICT_ACCEPT,    16'd60},
        '{0, 32'h0,        8'h4f, 8'h40, 1, 0, 59,    1, VERDICT_TRUNCATED, 16'd59},
        '{0, 32'h0,        8'h45, 8'h40, 1, 0, 19,    1, VERDICT_TRUNCATED, 16'd19},
        '{0, 32'h0,        8'h45, 8'h40, 1, 0, 1,     1, VERDICT_TRUNCATED, 16'd1},
        '{0, 32'h0,        8'h65, 8'h00, 0, 1, 19,    1, VERDICT_TRUNCATED, 16'd19},
        '{0, 32'h0,        8'h65, 8'h40, 1, 0, 20,    1, VERDICT_VERSION,   16'd20},
        '{0, 32'h0,        8'hf5, 8'h40, 1, 0, 20,    1, VERDICT_VERSION,   16'd20},
        '{0, 32'h0,        8'h05, 8'h40, 1, 0, 20,    1, VERDICT_VERSION,   16'd20},
        '{0, 32'h0,        8'h45, 8'h00, 1, 0, 20,    1, VERDICT_TTL,       16'd20},
        '{0, 32'h0,        8'h65, 8'h00, 1, 0, 20,    1, VERDICT_VERSION,   16'd20},
        '{0, 32'h0,        8'h44, 8'h40, 1, 0, 20,    1, VERDICT_HDR_LEN,   16'd20},
        '{0, 32'h0,        8'h40, 8'h40, 1, 0, 20,    1, VERDICT_HDR_LEN,   16'd20},
        '{0, 32'h0,        8'h43, 8'h00, 0, 1, 20,    1, VERDICT_TTL,       16'd20},
        '{0, 32'h0,        8'h43, 8'h40, 0, 1, 20,    1, VERDICT_HDR_LEN,   16'd20},
        '{0, 32'h0,        8'h45, 8'h40, 0, 0, 20,    1, VERDICT_DEST,      16'd20},
        '{0, 32'h0,        8'h45, 8'h40, 0, 1, 20,    1, VERDICT_DEST,      16'd20},
        '{0, 32'h0,        8'h45, 8'h40, 1, 1, 20,    1, VERDICT_CHECKSUM,  16'd20},
        '{0, 32'h0,        8'h46, 8'h80, 1, 0, 100,   0, VERDICT_ACCEPT,    16'd0},
        '{1, 32'h0,        8'h45, 8'h40, 1, 0, 20,    1, VERDICT_ACCEPT,    16'd20},
        '{0, 32'h0,        8'h45, 8'h40, 1, 0, 65540, 1, VERDICT_ACCEPT,    16'hffff}
    };

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    ihrc_in_if  in_ch ();
    ihrc_out_if out_ch ();

    ipv4_header_receive_check_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the per-packet state and the local address
    logic [15:0] rx_pos;
    logic [7:0]  rx_ver_ihl;
    logic [7:0]  rx_ttl;
    logic [31:0] rx_dest;
    logic [15:0] rx_sum;
    logic [7:0]  rx_hi;
    logic [31:0] cfg_local_addr;

    t_result    verdicts_due [$];
    logic [7:0] pkt_buf [$];
    int         bytes_sent;
    int         verdicts_queued;
    int         in_gap_max;
    int         out_stall_max;
    int         out_hold;
    int         cycle_count;
    bit         failed;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // runs the header checks on one accepted byte, gives a verdict on the final byte
    task automatic track_byte(input logic [7:0] b, input logic is_last,
                              output bit has_verdict, output t_result res);
        logic [15:0] pos;
        logic [16:0] acc;
        int          hdr_len;
        pos = rx_pos;
        has_verdict = 0;
        res = '0;
        if (pos == 0) rx_ver_ihl = b;
        if (pos == TTL_POS) rx_ttl = b;
        if (pos >= DEST_FIRST && pos <= DEST_LAST) rx_dest = {rx_dest[23:0], b};
        hdr_len = 4 * rx_ver_ihl[3:0];
        if (pos < hdr_len) begin
            if (!pos[0]) begin
                rx_hi = b;
            end else begin
                acc = {1'b0, rx_sum} + {1'b0, rx_hi, b};
                // end-around carry
                rx_sum = acc[15:0] + 16'(acc[16]);
            end
        end
        if (rx_pos != COUNT_MAX) rx_pos = rx_pos + 16'd1;
        if (is_last) begin
            has_verdict = 1;
            if (rx_pos < MIN_HDR_LEN || rx_pos < hdr_len) res.verdict = VERDICT_TRUNCATED;
            else if (rx_ver_ihl[7:4] != IP_VERSION) res.verdict = VERDICT_VERSION;
            else if (rx_ttl == 8'd0) res.verdict = VERDICT_TTL;
            else if (rx_ver_ihl[3:0] < MIN_IHL) res.verdict = VERDICT_HDR_LEN;
            else if (rx_dest != cfg_local_addr) res.verdict = VERDICT_DEST;
            else if (rx_sum != SUM_GOOD) res.verdict = VERDICT_CHECKSUM;
            else res.verdict = VERDICT_ACCEPT;
            res.packet_bytes = rx_pos;
            rx_pos = '0;
            rx_ver_ihl = '0;
            rx_ttl = '0;
            rx_dest = '0;
            rx_sum = '0;
            rx_hi = '0;
        end
    endtask

    // header with a correct sum over its words unless bad_sum, then random payload
    task automatic build_packet(input logic [7:0] ver_ihl, input logic [7:0] ttl,
                                input logic [31:0] dest, input bit bad_sum, input int len);
        logic [7:0]  hdr [60];
        logic [16:0] acc;
        logic [15:0] ck;
        int          hdr_size;
        foreach (hdr[i]) hdr[i] = 8'($urandom);
        hdr[0] = ver_ihl;
        hdr[8] = ttl;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = dest;
        hdr[10] = 8'h00;
        hdr[11] = 8'h00;
        acc = '0;
        for (int w = 0; w < 2 * ver_ihl[3:0]; w++) begin
            acc = {1'b0, acc[15:0]} + {1'b0, hdr[2*w], hdr[2*w+1]};
            acc = {1'b0, acc[15:0]} + 17'(acc[16]);
        end
        ck = ~acc[15:0];
        hdr[10] = ck[15:8];
        hdr[11] = ck[7:0];
        if (bad_sum) hdr[10 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        hdr_size = (ver_ihl[3:0] > 5) ? 4 * ver_ihl[3:0] : 20;
        pkt_buf.delete();
        for (int i = 0; i < len; i++) pkt_buf.push_back((i < hdr_size) ? hdr[i] : 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last,
                             input bit typed, input t_result fixed_res);
        int      gap;
        bit      has_verdict;
        t_result res;
        gap = $urandom_range(0, in_gap_max);
        // junk on the lines while valid is low
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= 8'($urandom);
            in_ch.last_byte <= 1'($urandom_range(0, 1));
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= is_last;
        do @(posedge i_clk); while (!in_ch.ready);
        track_byte(b, is_last, has_verdict, res);
        if (has_verdict) begin
            verdicts_due.push_back(typed ? fixed_res : res);
            verdicts_queued++;
        end
        bytes_sent++;
    endtask

    task automatic send_packet(input bit typed, input t_verdict v, input logic [15:0] cnt);
        t_result fixed_res;
        fixed_res.verdict = v;
        fixed_res.packet_bytes = cnt;
        foreach (pkt_buf[i]) send_byte(pkt_buf[i], i == pkt_buf.size() - 1, typed, fixed_res);
    endtask

    // lets every verdict come out and the pipeline empty before a register write
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_LOCAL_ADDRESS) cfg_local_addr = value;
    endtask

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_ch.ready <= 1'b0;
            out_hold = out_hold - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                $error("verdict item with none expected: verdict %0d packet_bytes %0d",
                       out_ch.verdict, out_ch.packet_bytes);
                failed = 1;
            end else begin
                want = verdicts_due.pop_front();
                if (out_ch.verdict !== want.verdict) begin
                    $error("verdict mismatch: expected %0d actual %0d",
                           want.verdict, out_ch.verdict);
                    failed = 1;
                end
                if (out_ch.packet_bytes !== want.packet_bytes) begin
                    $error("packet_bytes mismatch: expected %0d actual %0d",
                           want.packet_bytes, out_ch.packet_bytes);
                    failed = 1;
                end
            end
            out_hold = $urandom_range(0, out_stall_max);
        end
    end

    initial begin
        t_case       c;
        logic [31:0] dest_v;
        logic [31:0] next_addr;
        logic [7:0]  vi;
        logic [7:0]  ttl_v;
        bit          bad;
        int          kind;
        int          hdr_size;
        int          len;
        int          pkt_index;
        int          random_base;
        int          verdict_base;

        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_pos = '0;
        rx_ver_ihl = '0;
        rx_ttl = '0;
        rx_dest = '0;
        rx_sum = '0;
        rx_hi = '0;
        cfg_local_addr = '0;
        bytes_sent = 0;
        verdicts_queued = 0;
        in_gap_max = 9;
        out_stall_max = 9;
        out_hold = 0;
        cycle_count = 0;
        failed = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_cases[k]) begin
            c = directed_cases[k];
            if (c.set_local) begin
                drain();
                write_reg(REG_LOCAL_ADDRESS, c.local_value);
            end
            // the saturation packet goes through without gaps to keep the run short
            in_gap_max = (c.len > 1000) ? 0 : 9;
            dest_v = c.dest_ok ? cfg_local_addr
                               : cfg_local_addr ^ (32'd1 << $urandom_range(0, 31));
            build_packet(c.ver_ihl, c.ttl, dest_v, c.bad_sum, c.len);
            send_packet(c.typed, c.verdict, c.count);
        end

        random_base = bytes_sent;
        verdict_base = verdicts_queued;
        pkt_index = 0;
        while ((bytes_sent - random_base) < RANDOM_BYTES
               || (verdicts_queued - verdict_base) < MIN_RANDOM_VERDICTS) begin
            if (pkt_index % 8 == 0) begin
                drain();
                case ($urandom_range(0, 3))
                    0: next_addr = 32'h0;
                    1: next_addr = 32'hffffffff;
                    default: next_addr = $urandom;
                endcase
                write_reg(REG_LOCAL_ADDRESS, next_addr);
                in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
                out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
            end
            kind = $urandom_range(0, 99);
            vi = {IP_VERSION, ($urandom_range(0, 9) < 7) ? MIN_IHL : 4'($urandom_range(5, 15))};
            if ($urandom_range(0, 19) == 0) vi[7:4] = 4'($urandom);
            if ($urandom_range(0, 19) == 0) vi[3:0] = 4'($urandom);
            ttl_v = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            case ($urandom_range(0, 19))
                0: dest_v = $urandom;
                1: dest_v = cfg_local_addr ^ (32'd1 << $urandom_range(0, 31));
                default: dest_v = cfg_local_addr;
            endcase
            bad = ($urandom_range(0, 9) == 0);
            hdr_size = (vi[3:0] > 5) ? 4 * vi[3:0] : 20;
            // mostly whole packets, some cut inside the header, a few pure noise
            if (kind < 75) len = hdr_size + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 24));
            else if (kind < 90) len = $urandom_range(1, hdr_size - 1);
            else len = $urandom_range(1, 40);
            build_packet(vi, ttl_v, dest_v, bad, len);
            if (kind >= 90) foreach (pkt_buf[i]) pkt_buf[i] = 8'($urandom);
            send_packet(0, VERDICT_ACCEPT, 16'd0);
            pkt_index++;
        end

        drain();
        if (failed == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

[ipv4_header_receive_check_unit.f]
src/ihrc_pkg.sv
src/ihrc_in_if.sv
src/ihrc_out_if.sv
src/ihrc_hdr_track.sv
src/ipv4_header_receive_check_unit.sv
src/ihrc_checker.sv
test/ipv4_header_receive_check_unit_tb.sv
